[src/maac_pkg.sv]
package maac_pkg;

   // Shared multiply-accumulate widths
   localparam int OP_A_W = 28;
   localparam int OP_B_W = 19;
   localparam int ACC_W  = 48;
   localparam int DRV_W  = 16;
   localparam int CLIMB_W = 24;
   localparam int VEL_W  = 27;

   typedef logic signed [OP_A_W-1:0]  opa_type;
   typedef logic signed [OP_B_W-1:0]  opb_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [DRV_W-1:0]   drv_type;
   typedef logic signed [CLIMB_W-1:0] climb_type;

   // Accumulator base selection
   localparam logic [1:0] BASE_ZERO   = 2'd0;
   localparam logic [1:0] BASE_ACC    = 2'd1;
   localparam logic [1:0] BASE_CLAMP  = 2'd2;
   localparam logic [1:0] BASE_OFFSET = 2'd3;

   typedef struct packed {
      logic       en;
      logic [1:0] base_sel;
   } mac_ctl_type;

   // Gains, Q.18 (angle/rate) or Q.30 (stick), sign folded in
   localparam opb_type G_STICK      = 19'sd71583;
   localparam opb_type G_STICK_YAW  = 19'sd107374;
   localparam opb_type G_ROLL_ANG   = -19'sd78643;
   localparam opb_type G_ROLL_RATE  = -19'sd26214;
   localparam opb_type G_PITCH_ANG  = -19'sd94372;
   localparam opb_type G_PITCH_RATE = -19'sd31457;
   localparam opb_type G_YAW_RATE   = -19'sd131072;
   localparam opb_type G_HEADING    = 19'sd131072;
   localparam opb_type G_CLIMB_KEEP = 19'sd58982;
   localparam opb_type G_CLIMB_NEW  = 19'sd6554;
   localparam opb_type G_THROTTLE   = 19'sd78643;
   localparam opb_type G_ALTITUDE   = -19'sd52429;
   localparam opb_type G_CLIMB      = -19'sd26214;

   localparam acc_type THR_OFFSET = 48'sd322122547;
   localparam acc_type ONE_Q30    = 48'sd1073741824;
   localparam acc_type HALF_Q16   = 48'sd32768;
   localparam acc_type DRV_MAX    = 48'sd16384;
   localparam acc_type CLIMB_MAX  = 48'sd8388607;
   localparam acc_type CLIMB_MIN  = -48'sd8388608;

   localparam logic signed [17:0] PI_Q12     = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

   // Q.30 sum to Q1.14 with round half up, clamped to +-1
   function automatic drv_type to_drive(input acc_type acc);
      acc_type r;
      r = (acc + HALF_Q16) >>> 16;
      if (r > DRV_MAX) begin
         r = DRV_MAX;
      end else if (r < -DRV_MAX) begin
         r = -DRV_MAX;
      end
      return r[DRV_W-1:0];
   endfunction

   function automatic acc_type clamp_q30(input acc_type acc);
      acc_type r;
      r = acc;
      if (r > ONE_Q30) begin
         r = ONE_Q30;
      end else if (r < -ONE_Q30) begin
         r = -ONE_Q30;
      end
      return r;
   endfunction

   function automatic climb_type climb_round(input acc_type acc);
      acc_type r;
      r = (acc + HALF_Q16) >>> 16;
      if (r > CLIMB_MAX) begin
         r = CLIMB_MAX;
      end else if (r < CLIMB_MIN) begin
         r = CLIMB_MIN;
      end
      return r[CLIMB_W-1:0];
   endfunction

endpackage

[src/maac_if.sv]
interface maac_req_if;
   logic               valid;
   logic               ready;
   logic signed [13:0] stick_roll;
   logic signed [13:0] stick_pitch;
   logic signed [13:0] stick_yaw;
   logic [12:0]        stick_throttle;
   logic signed [15:0] roll_att;
   logic signed [15:0] pitch_att;
   logic signed [14:0] heading;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;
   logic signed [15:0] altitude;
   logic               run_permitted;

   modport source (
      output valid, stick_roll, stick_pitch, stick_yaw, stick_throttle, roll_att,
             pitch_att, heading, rate_x, rate_y, rate_z, altitude, run_permitted,
      input  ready
   );
   modport sink (
      input  valid, stick_roll, stick_pitch, stick_yaw, stick_throttle, roll_att,
             pitch_att, heading, rate_x, rate_y, rate_z, altitude, run_permitted,
      output ready
   );
endinterface

interface maac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_drive;
   logic signed [15:0] pitch_drive;
   logic signed [15:0] yaw_drive;
   logic signed [15:0] throttle_drive;
   logic               disarm;

   modport source (
      output valid, roll_drive, pitch_drive, yaw_drive, throttle_drive, disarm,
      input  ready
   );
   modport sink (
      input  valid, roll_drive, pitch_drive, yaw_drive, throttle_drive, disarm,
      output ready
   );
endinterface

[src/maac_mac.sv]
module maac_mac (
   input  logic                 clock,
   input  maac_pkg::mac_ctl_type ctl,
   input  maac_pkg::opa_type    op_a,
   input  maac_pkg::opb_type    op_b,
   output maac_pkg::acc_type    acc
);
   import maac_pkg::*;

   acc_type acc_ff, acc_in, base;
   logic signed [OP_A_W+OP_B_W-1:0] prod;

   always_comb begin
      prod = op_a * op_b;
      case (ctl.base_sel)
         BASE_ZERO:   base = '0;
         BASE_ACC:    base = acc_ff;
         BASE_CLAMP:  base = clamp_q30(acc_ff);
         BASE_OFFSET: base = THR_OFFSET;
         default:     base = '0;
      endcase
      // accumulate only on an active step, hold otherwise
      acc_in = ctl.en ? base + ACC_W'(prod) : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[src/multirotor_attitude_altitude_controller_unit.sv]
// A tick runs on the single shared 28x19 multiply-accumulate: 16 products in sequence
//   after the request is taken, then a finish step that loads the response register.
//   No new request is taken while a tick is in work; a response still waiting at the
//   finish step holds the unit until it is taken.
// Reset (synchronous, active high): idle, no response pending, heading, previous
//   altitude and climb filter cleared, loop rate 100 Hz, tilt limit 3277.
module multirotor_attitude_altitude_controller_unit (
   input  logic                          clock,
   input  logic                          reset,
   maac_req_if.sink                      req_chan,
   maac_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [13:0]                   csr_wdata
);
   import maac_pkg::*;

   // Register indexes
   localparam logic [0:0] CSR_LOOP_RATE = 1'b0;
   localparam logic [0:0] CSR_MAX_TILT  = 1'b1;

   // Sequencer steps: one multiply-accumulate each but the last
   localparam logic [4:0] S_R0   = 5'd0;   // roll stick
   localparam logic [4:0] S_R1   = 5'd1;   // roll angle
   localparam logic [4:0] S_R2   = 5'd2;   // roll rate
   localparam logic [4:0] S_P0   = 5'd3;   // pitch stick, store roll
   localparam logic [4:0] S_P1   = 5'd4;   // pitch angle
   localparam logic [4:0] S_P2   = 5'd5;   // pitch rate
   localparam logic [4:0] S_Y0   = 5'd6;   // yaw stick, store pitch
   localparam logic [4:0] S_Y1   = 5'd7;   // yaw gyro
   localparam logic [4:0] S_Y2   = 5'd8;   // heading error on clamped rate term
   localparam logic [4:0] S_Y3   = 5'd9;   // yaw stick heading term
   localparam logic [4:0] S_VEL  = 5'd10;  // altitude step times loop rate, store yaw
   localparam logic [4:0] S_C0   = 5'd11;  // keep part of filter, store velocity
   localparam logic [4:0] S_C1   = 5'd12;  // new part of filter
   localparam logic [4:0] S_T0   = 5'd13;  // offset plus throttle, store climb
   localparam logic [4:0] S_T1   = 5'd14;  // altitude
   localparam logic [4:0] S_T2   = 5'd15;  // climb damping
   localparam logic [4:0] S_DONE = 5'd16;  // load response register

   // Control
   logic       busy_ff, busy_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Configuration
   logic [9:0]  rate_ff, rate_in;
   logic [13:0] tilt_ff, tilt_in;

   // Captured tick
   logic signed [13:0] sr_ff, sp_ff, sy_ff;
   logic [12:0]        thr_ff;
   logic signed [15:0] ra_ff, pa_ff, gx_ff, gy_ff, gz_ff, alt_ff;
   logic signed [14:0] ya_ff;
   logic               trip_ff, off_ff;

   // Persistent state
   logic signed [15:0]    held_ff, held_in;
   logic signed [15:0]    prev_ff, prev_in;
   climb_type             climb_ff, climb_in;
   logic signed [VEL_W-1:0] vel_ff, vel_in;

   // Partial drives and response payload
   drv_type roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   drv_type out_roll_ff, out_pitch_ff, out_yaw_ff, out_thr_ff;
   drv_type out_roll_in, out_pitch_in, out_yaw_in, out_thr_in;
   logic    out_disarm_ff, out_disarm_in;

   // Shared unit
   mac_ctl_type mac_ctl;
   opa_type     op_a;
   opb_type     op_b;
   acc_type     acc;

   logic               accept, out_free, trip;
   logic signed [16:0] tilt_s, ra_s, pa_s, alt_diff;
   logic signed [17:0] err_raw, err_lo, err;

   maac_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Tilt failsafe on the incoming tick
   always_comb begin
      tilt_s = 17'(tilt_ff);
      ra_s   = 17'(req_chan.roll_att);
      pa_s   = 17'(req_chan.pitch_att);
      trip   = (ra_s > tilt_s) || (ra_s < -tilt_s) || (pa_s > tilt_s) || (pa_s < -tilt_s);
   end

   // Heading error, wrapped once into +-pi
   always_comb begin
      err_raw = 18'(held_ff) - 18'(ya_ff);
      err_lo  = (err_raw > PI_Q12) ? err_raw - TWO_PI_Q12 : err_raw;
      err     = (err_lo < -PI_Q12) ? err_lo + TWO_PI_Q12 : err_lo;
      alt_diff = 17'(alt_ff) - 17'(prev_ff);
   end

   // Operand selection per step
   always_comb begin
      mac_ctl = '{en: busy_ff, base_sel: BASE_ACC};
      op_a    = '0;
      op_b    = '0;
      case (step_ff)
         S_R0: begin
            mac_ctl.base_sel = BASE_ZERO;
            op_a = OP_A_W'(sr_ff);
            op_b = G_STICK;
         end
         S_R1: begin
            op_a = OP_A_W'(ra_ff);
            op_b = G_ROLL_ANG;
         end
         S_R2: begin
            op_a = OP_A_W'(gx_ff);
            op_b = G_ROLL_RATE;
         end
         S_P0: begin
            mac_ctl.base_sel = BASE_ZERO;
            op_a = OP_A_W'(sp_ff);
            op_b = G_STICK;
         end
         S_P1: begin
            op_a = OP_A_W'(pa_ff);
            op_b = G_PITCH_ANG;
         end
         S_P2: begin
            op_a = OP_A_W'(gy_ff);
            op_b = G_PITCH_RATE;
         end
         S_Y0: begin
            mac_ctl.base_sel = BASE_ZERO;
            op_a = OP_A_W'(sy_ff);
            op_b = G_STICK;
         end
         S_Y1: begin
            op_a = OP_A_W'(gz_ff);
            op_b = G_YAW_RATE;
         end
         S_Y2: begin
            // rate term saturates to +-1 before the heading term joins
            mac_ctl.base_sel = BASE_CLAMP;
            op_a = OP_A_W'(err);
            op_b = G_HEADING;
         end
         S_Y3: begin
            op_a = OP_A_W'(sy_ff);
            op_b = G_STICK_YAW;
         end
         S_VEL: begin
            mac_ctl.base_sel = BASE_ZERO;
            op_a = OP_A_W'(alt_diff);
            op_b = OP_B_W'(rate_ff);
         end
         S_C0: begin
            mac_ctl.base_sel = BASE_ZERO;
            op_a = OP_A_W'(climb_ff);
            op_b = G_CLIMB_KEEP;
         end
         S_C1: begin
            op_a = OP_A_W'(vel_ff);
            op_b = G_CLIMB_NEW;
         end
         S_T0: begin
            mac_ctl.base_sel = BASE_OFFSET;
            op_a = OP_A_W'(thr_ff);
            op_b = G_THROTTLE;
         end
         S_T1: begin
            op_a = OP_A_W'(alt_ff);
            op_b = G_ALTITUDE;
         end
         S_T2: begin
            op_a = OP_A_W'(climb_ff);
            op_b = G_CLIMB;
         end
         S_DONE: begin
            mac_ctl.en = 1'b0;
         end
         default: begin
            mac_ctl.en = 1'b0;
         end
      endcase
   end

   // Sequencer and write-back
   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      rate_in       = rate_ff;
      tilt_in       = tilt_ff;
      held_in       = held_ff;
      prev_in       = prev_ff;
      climb_in      = climb_ff;
      vel_in        = vel_ff;
      roll_in       = roll_ff;
      pitch_in      = pitch_ff;
      yaw_in        = yaw_ff;
      out_roll_in   = out_roll_ff;
      out_pitch_in  = out_pitch_ff;
      out_yaw_in    = out_yaw_ff;
      out_thr_in    = out_thr_ff;
      out_disarm_in = out_disarm_ff;

      // drop the response once the sink takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_LOOP_RATE: rate_in = csr_wdata[9:0];
            CSR_MAX_TILT:  tilt_in = csr_wdata;
            default:       rate_in = rate_ff;
         endcase
      end

      if (accept) begin
         busy_in = 1'b1;
         step_in = S_R0;
         // latch heading on a yaw stick command; track heading while not running
         if (req_chan.stick_yaw != '0 || trip || !req_chan.run_permitted) begin
            held_in = 16'(req_chan.heading);
         end
      end else if (busy_ff) begin
         if (step_ff != S_DONE) begin
            step_in = step_ff + 5'd1;
         end
         case (step_ff)
            S_P0:  roll_in  = to_drive(acc);
            S_Y0:  pitch_in = to_drive(acc);
            S_VEL: begin
               yaw_in  = to_drive(acc);
               prev_in = alt_ff;
            end
            S_C0:  vel_in   = acc[VEL_W-1:0];
            S_T0:  climb_in = climb_round(acc);
            S_DONE: begin
               // hold here while the previous response still waits
               if (out_free) begin
                  busy_in       = 1'b0;
                  rsp_valid_in  = 1'b1;
                  out_roll_in   = off_ff ? '0 : roll_ff;
                  out_pitch_in  = off_ff ? '0 : pitch_ff;
                  out_yaw_in    = off_ff ? '0 : yaw_ff;
                  out_thr_in    = off_ff ? '0 : to_drive(acc);
                  out_disarm_in = trip_ff;
               end
            end
            default: step_in = step_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= S_R0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= 10'd100;
         tilt_ff      <= 14'd3277;
         held_ff      <= '0;
         prev_ff      <= '0;
         climb_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         tilt_ff      <= tilt_in;
         held_ff      <= held_in;
         prev_ff      <= prev_in;
         climb_ff     <= climb_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         sr_ff   <= req_chan.stick_roll;
         sp_ff   <= req_chan.stick_pitch;
         sy_ff   <= req_chan.stick_yaw;
         thr_ff  <= req_chan.stick_throttle;
         ra_ff   <= req_chan.roll_att;
         pa_ff   <= req_chan.pitch_att;
         ya_ff   <= req_chan.heading;
         gx_ff   <= req_chan.rate_x;
         gy_ff   <= req_chan.rate_y;
         gz_ff   <= req_chan.rate_z;
         alt_ff  <= req_chan.altitude;
         trip_ff <= trip;
         off_ff  <= trip || !req_chan.run_permitted;
      end
      vel_ff        <= vel_in;
      roll_ff       <= roll_in;
      pitch_ff      <= pitch_in;
      yaw_ff        <= yaw_in;
      out_roll_ff   <= out_roll_in;
      out_pitch_ff  <= out_pitch_in;
      out_yaw_ff    <= out_yaw_in;
      out_thr_ff    <= out_thr_in;
      out_disarm_ff <= out_disarm_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.roll_drive     = out_roll_ff;
   assign rsp_chan.pitch_drive    = out_pitch_ff;
   assign rsp_chan.yaw_drive      = out_yaw_ff;
   assign rsp_chan.throttle_drive = out_thr_ff;
   assign rsp_chan.disarm         = out_disarm_ff;

endmodule

[src/maac_checker.sv]
module maac_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_roll_drive,
   input logic signed [15:0] rsp_pitch_drive,
   input logic signed [15:0] rsp_yaw_drive,
   input logic signed [15:0] rsp_throttle_drive,
   input logic               rsp_disarm
);

   // a tick in work blocks the next transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a tick is in work");

   // failsafe forces all drives to zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_disarm) |->
         (rsp_roll_drive == 16'sd0 && rsp_pitch_drive == 16'sd0 &&
          rsp_yaw_drive == 16'sd0 && rsp_throttle_drive == 16'sd0))
      else $error("drive nonzero with disarm set");

   // drives stay within +-1.0 in Q1.14
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_roll_drive >= -16'sd16384 && rsp_roll_drive <= 16'sd16384 &&
          rsp_pitch_drive >= -16'sd16384 && rsp_pitch_drive <= 16'sd16384 &&
          rsp_yaw_drive >= -16'sd16384 && rsp_yaw_drive <= 16'sd16384 &&
          rsp_throttle_drive >= -16'sd16384 && rsp_throttle_drive <= 16'sd16384))
      else $error("drive out of range");

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_roll_drive) && $stable(rsp_pitch_drive) &&
          $stable(rsp_yaw_drive) && $stable(rsp_throttle_drive) && $stable(rsp_disarm)))
      else $error("stalled response changed");

endmodule

bind multirotor_attitude_altitude_controller_unit maac_checker u_maac_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_roll_drive     (rsp_chan.roll_drive),
   .rsp_pitch_drive    (rsp_chan.pitch_drive),
   .rsp_yaw_drive      (rsp_chan.yaw_drive),
   .rsp_throttle_drive (rsp_chan.throttle_drive),
   .rsp_disarm         (rsp_chan.disarm)
);
